[sv/eu_dst_local_time_offset_unit_assert.svh]
// Assertion macros used by the checker file of this block.
`ifndef EU_DST_LOCAL_TIME_OFFSET_UNIT_ASSERT_SVH
`define EU_DST_LOCAL_TIME_OFFSET_UNIT_ASSERT_SVH

// Property checked on every rising clock edge outside of reset.
`define EUDST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("eudst port check failed");

// Property checked on every rising clock edge, reset included.
`define EUDST_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("eudst reset check failed");

`endif

[sv/eudst_pkg.sv]
package eudst_pkg;

    // Field widths.
    localparam int UTC_W    = 32;
    localparam int OFFSET_W = 17;
    localparam int LOCAL_W  = 33;
    localparam int ZONE_W   = 11;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 11;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // Pipeline depth: calendar stages, then rule, decision and output stages.
    localparam int CAL_STAGES = 11;
    localparam int NUM_STAGES = 14;

    // Configuration register indexes.
    localparam logic CFG_ZONE = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // Summer time modes.
    localparam logic [1:0] MODE_STANDARD = 2'd0;
    localparam logic [1:0] MODE_SUMMER   = 2'd1;
    localparam logic [1:0] MODE_AUTO     = 2'd2;
    localparam logic [1:0] MODE_STD_ALT  = 2'd3;

    // Time constants.
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int SUMMER_EXTRA  = 3600;

    // Day split: the seconds count is shifted down by 7, then divided by 675.
    localparam int DAY_DIV = 675;
    localparam int DAY_MUL = 49710;     // floor(2^25 / 675)
    // Calendar constants (eras start on March 1; ERA_SPLIT counts days from 1970-01-01).
    localparam int ERA_SPLIT   = 11017; // first day of the era starting in 2000
    localparam int ERA4_OFFSET = 135080;
    localparam int DAYS_4Y     = 1460;
    localparam int DAYS_4Y_MUL = 179;   // floor(2^18 / 1460)
    localparam int DAYS_100Y   = 36524;
    localparam int DAYS_400Y_M1 = 146096;
    localparam int DAYS_Y      = 365;
    localparam int DAYS_Y_MUL  = 718;   // floor(2^18 / 365)
    localparam int MP_DIV      = 153;
    localparam int MP_MUL      = 13;    // floor(2^11 / 153)
    localparam int WEEK        = 7;
    localparam int WEEK_MUL    = 585;   // floor(2^12 / 7)
    localparam int MONTH_DAYS  = 31;

    // Civil UTC date of one timestamp, with the timestamp itself and an hour-past-zero flag.
    typedef struct packed {
        logic [31:0] utc;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        hour_ge1;
    } date_t;

    // Day of the year (from March 1) on which month index mp starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[sv/eu_dst_local_time_offset_unit.sv]
// EU summer time offset unit. Each input beat carries a UTC second count since
// 1970; each output beat carries the total local offset in seconds, the summer
// flag and the local second count. The unit is a 14-stage pipeline: it takes
// one beat per cycle while the output side takes its results, and a result is
// offered on m_tvalid from the last stage register, where it is held while the
// output side stalls. Each stage holds its beat until the next stage has room,
// so s_tready stays high as long as a bubble is left anywhere in the pipeline.
// Configuration is written through cfg_we, cfg_index and cfg_data and takes
// effect on the beats that reach the last stage after the write; write it only
// while the pipeline is empty.
module eu_dst_local_time_offset_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [eudst_pkg::CFG_W-1:0]         cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [eudst_pkg::IN_DATA_W-1:0]     s_tdata,   // [31:0] utc_seconds
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [eudst_pkg::OUT_DATA_W-1:0]    m_tdata    // [16:0] offset_seconds,
                                                           // [17] summer_active,
                                                           // [50:18] local_seconds,
                                                           // [55:51] zero
);
    import eudst_pkg::*;

    // Configuration registers.
    logic signed [ZONE_W-1:0] zone_reg;
    logic [MODE_W-1:0]        mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
            mode_reg <= MODE_STANDARD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZONE: zone_reg <= cfg_data[ZONE_W-1:0];
                CFG_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                default:  ;
            endcase
        end
    end

    // Stage valid bits and per-stage advance enables.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NUM_STAGES-1];

    // Calendar split of the UTC time.
    date_t cal_date;

    eudst_calendar u_calendar (
        .clk         (clk),
        .en          (en[CAL_STAGES-1:0]),
        .utc_seconds (s_tdata[UTC_W-1:0]),
        .date        (cal_date)
    );

    // Rule stage: value whose remainder by 7 places the last Sunday.
    logic [13:0] r_five_y;
    logic [11:0] r_v;
    logic [21:0] r_prod;
    date_t       r_date_reg;
    logic [11:0] r_v_reg;
    logic [9:0]  r_q_reg;

    assign r_five_y = 14'(cal_date.year) * 14'd5;
    assign r_v      = r_five_y[13:2] + ((cal_date.month == 4'd3) ? 12'd4 : 12'd1);
    assign r_prod   = 22'(r_v) * 22'(WEEK_MUL);

    always_ff @(posedge clk)
    begin
        if (en[CAL_STAGES])
        begin
            r_date_reg <= cal_date;
            r_v_reg    <= r_v;
            r_q_reg    <= r_prod[21:12];
        end
    end

    // Decision stage: last Sunday of the month and the EU summer test.
    logic [11:0] d_qd;
    logic [11:0] d_rfull;
    logic [3:0]  d_r;
    logic [2:0]  d_rem;
    logic [4:0]  d_last;
    logic        d_eu;
    logic        d_is_mar;
    logic        d_is_oct;
    logic [31:0] d_t_reg;
    logic        d_eu_reg;

    assign d_qd     = 12'(r_q_reg) * 12'(WEEK);
    assign d_rfull  = r_v_reg - d_qd;
    assign d_r      = d_rfull[3:0];
    assign d_rem    = (d_r >= 4'(WEEK)) ? 3'(d_r - 4'(WEEK)) : d_r[2:0];
    assign d_last   = 5'(MONTH_DAYS) - 5'(d_rem);
    assign d_is_mar = (r_date_reg.month == 4'd3);
    assign d_is_oct = (r_date_reg.month == 4'd10);

    always_comb
    begin
        priority if (r_date_reg.month < 4'd3 || r_date_reg.month > 4'd10)
        begin
            d_eu = 1'b0;
        end
        else if (!d_is_mar && !d_is_oct)
        begin
            d_eu = 1'b1;
        end
        else if (r_date_reg.day < d_last)
        begin
            d_eu = d_is_oct;
        end
        else if (r_date_reg.day > d_last)
        begin
            d_eu = d_is_mar;
        end
        else
        begin
            // On the switch day the change happens at 01:00 UTC.
            d_eu = d_is_mar ? r_date_reg.hour_ge1 : !r_date_reg.hour_ge1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[CAL_STAGES+1])
        begin
            d_t_reg  <= r_date_reg.utc;
            d_eu_reg <= d_eu;
        end
    end

    // Output stage: apply the mode, form the offset and the local time.
    logic                       o_summer;
    logic signed [OFFSET_W-1:0] o_zone_ext;
    logic signed [OFFSET_W-1:0] o_offset;
    logic [LOCAL_W-1:0]         o_local;
    logic [OFFSET_W-1:0]        o_offset_reg;
    logic                       o_summer_reg;
    logic [LOCAL_W-1:0]         o_local_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_STANDARD: o_summer = 1'b0;
            MODE_SUMMER:   o_summer = 1'b1;
            MODE_AUTO:     o_summer = d_eu_reg;
            MODE_STD_ALT:  o_summer = 1'b0;
            default:       o_summer = 1'b0;
        endcase
    end

    assign o_zone_ext = OFFSET_W'(zone_reg);
    assign o_offset   = OFFSET_W'(o_zone_ext * OFFSET_W'(SECS_PER_MIN))
                      + (o_summer ? OFFSET_W'(SUMMER_EXTRA) : OFFSET_W'(0));
    assign o_local    = LOCAL_W'(d_t_reg) + LOCAL_W'(o_offset);

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            o_offset_reg <= o_offset;
            o_summer_reg <= o_summer;
            o_local_reg  <= o_local;
        end
    end

    assign m_tdata = {5'd0, o_local_reg, o_summer_reg, o_offset_reg};

endmodule

[sv/eudst_calendar.sv]
module eudst_calendar (
    input  logic                             clk,
    input  logic [eudst_pkg::CAL_STAGES-1:0] en,
    input  logic [31:0]                      utc_seconds,
    output eudst_pkg::date_t                 date
);
    import eudst_pkg::*;

    // Stage 0: estimate of the day count, possibly one low.
    logic [40:0] s0_prod;
    logic [31:0] s0_t_reg;
    logic [15:0] s0_q_reg;

    assign s0_prod = 41'(utc_seconds[31:7]) * 41'(DAY_MUL);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_t_reg <= utc_seconds;
            s0_q_reg <= s0_prod[40:25];
        end
    end

    // Stage 1: correct the day count and note whether the hour is past zero.
    logic [25:0] s1_qd;
    logic [24:0] s1_rfull;
    logic [10:0] s1_r;
    logic        s1_fix;
    logic [10:0] s1_rr;
    logic [16:0] s1_secs;
    logic [31:0] s1_t_reg;
    logic [15:0] s1_days_reg;
    logic        s1_hge1_reg;

    assign s1_qd    = 26'(s0_q_reg) * 26'(DAY_DIV);
    assign s1_rfull = s0_t_reg[31:7] - s1_qd[24:0];
    assign s1_r     = s1_rfull[10:0];
    assign s1_fix   = (s1_r >= 11'(DAY_DIV));
    assign s1_rr    = s1_fix ? (s1_r - 11'(DAY_DIV)) : s1_r;
    assign s1_secs  = {s1_rr[9:0], s0_t_reg[6:0]};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_t_reg    <= s0_t_reg;
            s1_days_reg <= s0_q_reg + 16'(s1_fix);
            s1_hge1_reg <= (s1_secs >= 17'(SECS_PER_HOUR));
        end
    end

    // Stage 2: era (1600 or 2000) and day of the era.
    logic [31:0] s2_t_reg;
    logic [17:0] s2_doe_reg;
    logic        s2_era_reg;
    logic        s2_hge1_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_t_reg    <= s1_t_reg;
            s2_hge1_reg <= s1_hge1_reg;
            if (s1_days_reg < 16'(ERA_SPLIT))
            begin
                s2_doe_reg <= 18'(s1_days_reg) + 18'(ERA4_OFFSET);
                s2_era_reg <= 1'b0;
            end
            else
            begin
                s2_doe_reg <= 18'(s1_days_reg) - 18'(ERA_SPLIT);
                s2_era_reg <= 1'b1;
            end
        end
    end

    // Stage 3: century count, end-of-era mark and four-year estimate.
    logic [25:0] s3_prod;
    logic [2:0]  s3_cent;
    logic [31:0] s3_t_reg;
    logic [17:0] s3_doe_reg;
    logic        s3_era_reg;
    logic        s3_hge1_reg;
    logic [7:0]  s3_aq_reg;
    logic [2:0]  s3_cent_reg;
    logic        s3_last_reg;

    assign s3_prod = 26'(s2_doe_reg) * 26'(DAYS_4Y_MUL);
    assign s3_cent = 3'(s2_doe_reg >= 18'(DAYS_100Y))
                   + 3'(s2_doe_reg >= 18'(2 * DAYS_100Y))
                   + 3'(s2_doe_reg >= 18'(3 * DAYS_100Y))
                   + 3'(s2_doe_reg >= 18'(DAYS_400Y_M1));

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_t_reg    <= s2_t_reg;
            s3_doe_reg  <= s2_doe_reg;
            s3_era_reg  <= s2_era_reg;
            s3_hge1_reg <= s2_hge1_reg;
            s3_aq_reg   <= s3_prod[25:18];
            s3_cent_reg <= s3_cent;
            s3_last_reg <= (s2_doe_reg == 18'(DAYS_400Y_M1));
        end
    end

    // Stage 4: correct the four-year count and form the year numerator.
    logic [17:0] s4_aqd;
    logic [17:0] s4_r;
    logic [7:0]  s4_a;
    logic [31:0] s4_t_reg;
    logic [17:0] s4_doe_reg;
    logic        s4_era_reg;
    logic        s4_hge1_reg;
    logic [17:0] s4_n_reg;

    assign s4_aqd = 18'(s3_aq_reg) * 18'(DAYS_4Y);
    assign s4_r   = s3_doe_reg - s4_aqd;
    assign s4_a   = s3_aq_reg + 8'(s4_r >= 18'(DAYS_4Y));

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_t_reg    <= s3_t_reg;
            s4_doe_reg  <= s3_doe_reg;
            s4_era_reg  <= s3_era_reg;
            s4_hge1_reg <= s3_hge1_reg;
            s4_n_reg    <= s3_doe_reg - 18'(s4_a) + 18'(s3_cent_reg) - 18'(s3_last_reg);
        end
    end

    // Stage 5: estimate of the year of the era.
    logic [27:0] s5_prod;
    logic [31:0] s5_t_reg;
    logic [17:0] s5_doe_reg;
    logic        s5_era_reg;
    logic        s5_hge1_reg;
    logic [17:0] s5_n_reg;
    logic [9:0]  s5_yq_reg;

    assign s5_prod = 28'(s4_n_reg) * 28'(DAYS_Y_MUL);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_t_reg    <= s4_t_reg;
            s5_doe_reg  <= s4_doe_reg;
            s5_era_reg  <= s4_era_reg;
            s5_hge1_reg <= s4_hge1_reg;
            s5_n_reg    <= s4_n_reg;
            s5_yq_reg   <= s5_prod[27:18];
        end
    end

    // Stage 6: correct the year of the era.
    logic [17:0] s6_yqd;
    logic [17:0] s6_r;
    logic [9:0]  s6_yoe;
    logic [31:0] s6_t_reg;
    logic [17:0] s6_doe_reg;
    logic        s6_era_reg;
    logic        s6_hge1_reg;
    logic [8:0]  s6_yoe_reg;

    assign s6_yqd = 18'(s5_yq_reg) * 18'(DAYS_Y);
    assign s6_r   = s5_n_reg - s6_yqd;
    assign s6_yoe = s5_yq_reg + 10'(s6_r >= 18'(DAYS_Y));

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_t_reg    <= s5_t_reg;
            s6_doe_reg  <= s5_doe_reg;
            s6_era_reg  <= s5_era_reg;
            s6_hge1_reg <= s5_hge1_reg;
            s6_yoe_reg  <= s6_yoe[8:0];
        end
    end

    // Stage 7: day of the year, counted from March 1.
    logic [1:0]  s7_cent;
    logic [17:0] s7_base;
    logic [17:0] s7_doy;
    logic [31:0] s7_t_reg;
    logic        s7_era_reg;
    logic        s7_hge1_reg;
    logic [8:0]  s7_yoe_reg;
    logic [8:0]  s7_doy_reg;

    assign s7_cent = 2'(s6_yoe_reg >= 9'd100) + 2'(s6_yoe_reg >= 9'd200)
                   + 2'(s6_yoe_reg >= 9'd300);
    assign s7_base = 18'(s6_yoe_reg) * 18'(DAYS_Y) + 18'(s6_yoe_reg[8:2]) - 18'(s7_cent);
    assign s7_doy  = s6_doe_reg - s7_base;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_t_reg    <= s6_t_reg;
            s7_era_reg  <= s6_era_reg;
            s7_hge1_reg <= s6_hge1_reg;
            s7_yoe_reg  <= s6_yoe_reg;
            s7_doy_reg  <= s7_doy[8:0];
        end
    end

    // Stage 8: estimate of the month index.
    logic [10:0] s8_x;
    logic [14:0] s8_prod;
    logic [31:0] s8_t_reg;
    logic        s8_era_reg;
    logic        s8_hge1_reg;
    logic [8:0]  s8_yoe_reg;
    logic [8:0]  s8_doy_reg;
    logic [10:0] s8_x_reg;
    logic [3:0]  s8_mq_reg;

    assign s8_x    = 11'(s7_doy_reg) * 11'd5 + 11'd2;
    assign s8_prod = 15'(s8_x) * 15'(MP_MUL);

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_t_reg    <= s7_t_reg;
            s8_era_reg  <= s7_era_reg;
            s8_hge1_reg <= s7_hge1_reg;
            s8_yoe_reg  <= s7_yoe_reg;
            s8_doy_reg  <= s7_doy_reg;
            s8_x_reg    <= s8_x;
            s8_mq_reg   <= s8_prod[14:11];
        end
    end

    // Stage 9: correct the month index.
    logic [10:0] s9_mqd;
    logic [10:0] s9_r;
    logic [31:0] s9_t_reg;
    logic        s9_era_reg;
    logic        s9_hge1_reg;
    logic [8:0]  s9_yoe_reg;
    logic [8:0]  s9_doy_reg;
    logic [3:0]  s9_mp_reg;

    assign s9_mqd = 11'(s8_mq_reg) * 11'(MP_DIV);
    assign s9_r   = s8_x_reg - s9_mqd;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_t_reg    <= s8_t_reg;
            s9_era_reg  <= s8_era_reg;
            s9_hge1_reg <= s8_hge1_reg;
            s9_yoe_reg  <= s8_yoe_reg;
            s9_doy_reg  <= s8_doy_reg;
            s9_mp_reg   <= s8_mq_reg + 4'(s9_r >= 11'(MP_DIV));
        end
    end

    // Stage 10: civil month, day and year.
    logic [3:0]  s10_month;
    logic [8:0]  s10_day;
    logic [11:0] s10_year;
    date_t       s10_date_reg;

    assign s10_month = (s9_mp_reg < 4'd10) ? (s9_mp_reg + 4'd3) : (s9_mp_reg - 4'd9);
    assign s10_day   = s9_doy_reg - month_start(s9_mp_reg) + 9'd1;
    assign s10_year  = 12'(s9_yoe_reg) + (s9_era_reg ? 12'd2000 : 12'd1600)
                     + 12'(s10_month <= 4'd2);

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s10_date_reg.utc      <= s9_t_reg;
            s10_date_reg.year     <= s10_year;
            s10_date_reg.month    <= s10_month;
            s10_date_reg.day      <= s10_day[4:0];
            s10_date_reg.hour_ge1 <= s9_hge1_reg;
        end
    end

    assign date = s10_date_reg;

endmodule

[sv/eudst_checker.sv]
`include "eu_dst_local_time_offset_unit_assert.svh"

module eudst_assert_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // UTC time recovered from a result: local time minus the offset.
    logic [32:0] off_ext;
    logic [32:0] utc_back;

    assign off_ext  = 33'($signed(m_tdata[16:0]));
    assign utc_back = m_tdata[50:18] - off_ext;

    // A result that is not taken stays offered.
    `EUDST_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)

    // The padding bits above the local time are always zero.
    `EUDST_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[55:51] == 5'd0)

    // Local time minus offset must give back a 32-bit UTC time.
    `EUDST_ASSERT(a_local_sum, m_tvalid |-> utc_back[32] == 1'b0)

    // Nothing leaves the pipeline right after reset.
    `EUDST_ASSERT_RST(a_reset_quiet, !rst_n |=> !m_tvalid)

endmodule

bind eu_dst_local_time_offset_unit eudst_assert_checker u_eudst_checker (.*);
